// ----- rtl/pdmpm_pkg.sv -----
package pdmpm_pkg;

    localparam int PWM_BITS_DEF   = 12;
    localparam int COUNT_BITS_DEF = 16;
    localparam int FRAC_BITS      = 24;
    localparam int COEF_W         = 32;
    localparam int COEF_FRAC      = 30;
    localparam int PERIOD_W       = 16;
    localparam int OFFSET_W       = 16;
    localparam int LIMIT_W        = 11;
    localparam int SETPOINT_W     = 12;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    localparam logic signed [COEF_W-1:0] COEF_INPUT_RST   = 32'sd18919;
    localparam logic signed [COEF_W-1:0] COEF_OUT_ONE_RST = -32'sd2145239869;
    localparam logic signed [COEF_W-1:0] COEF_OUT_TWO_RST = 32'sd1071498041;
    localparam logic [PERIOD_W-1:0]      PERIOD_RST       = 16'd100;
    localparam logic [OFFSET_W-1:0]      OFFSET_RST       = 16'd510;
    localparam logic [LIMIT_W-1:0]       LIMIT_RST        = 11'd490;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_INPUT   = 3'd0,
        CFG_COEF_OUT_ONE = 3'd1,
        CFG_COEF_OUT_TWO = 3'd2,
        CFG_TICK_PERIOD  = 3'd3,
        CFG_PULSE_OFFSET = 3'd4,
        CFG_PULSE_LIMIT  = 3'd5
    } t_cfg_index;

endpackage

// ----- rtl/pdmpm_in_if.sv -----
interface pdmpm_in_if;
    logic valid;
    logic ready;
    logic pulse_level;
    logic cal_level;

    modport source (output valid, pulse_level, cal_level, input ready);
    modport sink   (input valid, pulse_level, cal_level, output ready);
endinterface

// ----- rtl/pdmpm_out_if.sv -----
interface pdmpm_out_if
    import pdmpm_pkg::*;
#(
    parameter int PWM_BITS = PWM_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [PWM_BITS-1:0]          pwm_level;
    logic signed [SETPOINT_W-1:0] setpoint;
    logic                         update_strobe;

    modport source (output valid, pwm_level, setpoint, update_strobe, input ready);
    modport sink   (input valid, pwm_level, setpoint, update_strobe, output ready);
endinterface

// ----- rtl/pulse_driven_motor_plant_model_unit.sv -----
// Motor plant model driven by a servo-style command pulse. Each input word is one
// microsecond sample of the pulse pin and the active-low calibrate pin; the block
// takes one word per clock unless stalled (see below); an accepted word is held in the
// input register, then an update's result in the result register. Every tick_period
// words it runs one update of a second-order IIR, y = a*x[n-2] - b*y[n-1] - c*y[n-2],
// with Q1.30 coefficients and y held with 24 fractional bits, and emits one result
// word: the integer part of y clamped to the PWM range, the latched setpoint and a
// strobe that toggles per update. The longest path is the y[n-1] feedback: one
// coefficient multiply, a three-term add and the output clamp. The input side
// only stalls when an update finds the result register still full.
module pulse_driven_motor_plant_model_unit
    import pdmpm_pkg::*;
#(
    parameter int PWM_BITS   = PWM_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pdmpm_in_if.sink              i_in,
    pdmpm_out_if.source           o_out
);

    localparam int Y_W      = PWM_BITS + FRAC_BITS;
    localparam int PROD_Y_W = COEF_W + Y_W + 1;
    localparam int PROD_X_W = COEF_W + SETPOINT_W;
    localparam int SUM_W    = Y_W + 8;
    localparam int X_SHIFT  = COEF_FRAC - FRAC_BITS;
    localparam int DIFF_W   = ((COUNT_BITS > OFFSET_W) ? COUNT_BITS : OFFSET_W) + 2;

    localparam logic [Y_W-1:0] Y_MAX = {{PWM_BITS{1'b1}}, {FRAC_BITS{1'b0}}};
    localparam logic [Y_W-1:0] Y_MID = Y_MAX >> 1;

    // configuration
    logic signed [COEF_W-1:0] r_coef_input;
    logic signed [COEF_W-1:0] r_coef_one;
    logic signed [COEF_W-1:0] r_coef_two;
    logic [PERIOD_W-1:0]      r_period;
    logic [OFFSET_W-1:0]      r_offset;
    logic [LIMIT_W-1:0]       r_limit;

    // input register
    logic r_in_valid;
    logic r_in_pulse;
    logic r_in_cal;

    // model state
    logic                         r_prev_pulse;
    logic [COUNT_BITS-1:0]        r_high_count;
    logic [PERIOD_W-1:0]          r_tick_count;
    logic signed [SETPOINT_W-1:0] r_setpoint;
    logic signed [SETPOINT_W-1:0] r_x1;
    logic signed [SETPOINT_W-1:0] r_x2;
    logic [Y_W-1:0]               r_y1;
    logic [Y_W-1:0]               r_y2;
    logic                         r_strobe;

    // result register
    logic                         r_out_valid;
    logic [PWM_BITS-1:0]          r_out_pwm;
    logic signed [SETPOINT_W-1:0] r_out_setpoint;
    logic                         r_out_strobe;

    logic [COUNT_BITS-1:0]        n_high_count;
    logic signed [SETPOINT_W-1:0] n_setpoint;
    logic [PERIOD_W-1:0]          n_tick_count;
    logic [Y_W-1:0]               n_y;

    logic signed [DIFF_W-1:0]     sp_diff;
    logic signed [DIFF_W-1:0]     sp_lim;
    logic signed [DIFF_W-1:0]     sp_clamped;
    logic [PERIOD_W:0]            tick_inc;
    logic [PERIOD_W-1:0]          period;
    logic                         update;
    logic                         advance;
    logic                         out_free;

    logic signed [PROD_X_W-1:0]   prod_x;
    logic signed [PROD_Y_W-1:0]   prod_y1;
    logic signed [PROD_Y_W-1:0]   prod_y2;
    logic signed [SUM_W-1:0]      term_x;
    logic signed [SUM_W-1:0]      term_y1;
    logic signed [SUM_W-1:0]      term_y2;
    logic signed [SUM_W-1:0]      y_sum;

    // pulse width measurement and setpoint latch
    always_comb begin
        sp_diff = $signed({{(DIFF_W-COUNT_BITS){1'b0}}, r_high_count})
                - $signed({{(DIFF_W-OFFSET_W){1'b0}}, r_offset});
        sp_lim  = $signed({{(DIFF_W-LIMIT_W){1'b0}}, r_limit});
        if (sp_diff < -sp_lim) begin
            sp_clamped = -sp_lim;
        end else if (sp_diff > sp_lim) begin
            sp_clamped = sp_lim;
        end else begin
            sp_clamped = sp_diff;
        end

        n_high_count = r_high_count;
        n_setpoint   = r_setpoint;
        if (r_in_pulse) begin
            if (!r_prev_pulse) begin
                n_high_count = COUNT_BITS'(1);
            end else if (r_high_count != {COUNT_BITS{1'b1}}) begin
                n_high_count = r_high_count + 1'b1;
            end
        end else if (r_prev_pulse) begin
            n_setpoint = SETPOINT_W'(sp_clamped);
        end
    end

    // update tick, a zero period behaves as one
    always_comb begin
        period       = (r_period == '0) ? PERIOD_W'(1) : r_period;
        tick_inc     = {1'b0, r_tick_count} + 1'b1;
        update       = tick_inc >= {1'b0, period};
        n_tick_count = update ? '0 : tick_inc[PERIOD_W-1:0];
    end

    // plant update: products floored back to 24 fractional bits
    assign prod_x  = r_coef_input * r_x2;
    assign prod_y1 = r_coef_one * $signed({1'b0, r_y1});
    assign prod_y2 = r_coef_two * $signed({1'b0, r_y2});
    assign term_x  = SUM_W'(prod_x >>> X_SHIFT);
    assign term_y1 = SUM_W'(prod_y1 >>> COEF_FRAC);
    assign term_y2 = SUM_W'(prod_y2 >>> COEF_FRAC);
    assign y_sum   = term_x - term_y1 - term_y2;

    always_comb begin
        if (!r_in_cal) begin
            n_y = Y_MID;
        end else if (y_sum < 0) begin
            n_y = '0;
        end else if (y_sum > $signed({{(SUM_W-Y_W){1'b0}}, Y_MAX})) begin
            n_y = Y_MAX;
        end else begin
            n_y = y_sum[Y_W-1:0];
        end
    end

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && (!update || out_free);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_input <= COEF_INPUT_RST;
            r_coef_one   <= COEF_OUT_ONE_RST;
            r_coef_two   <= COEF_OUT_TWO_RST;
            r_period     <= PERIOD_RST;
            r_offset     <= OFFSET_RST;
            r_limit      <= LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COEF_INPUT:   r_coef_input <= $signed(i_cfg_data[COEF_W-1:0]);
                CFG_COEF_OUT_ONE: r_coef_one   <= $signed(i_cfg_data[COEF_W-1:0]);
                CFG_COEF_OUT_TWO: r_coef_two   <= $signed(i_cfg_data[COEF_W-1:0]);
                CFG_TICK_PERIOD:  r_period     <= i_cfg_data[PERIOD_W-1:0];
                CFG_PULSE_OFFSET: r_offset     <= i_cfg_data[OFFSET_W-1:0];
                CFG_PULSE_LIMIT:  r_limit      <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_pulse <= i_in.pulse_level;
            r_in_cal   <= i_in.cal_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pulse <= 1'b0;
            r_high_count <= '0;
            r_tick_count <= '0;
            r_setpoint   <= '0;
            r_x1         <= '0;
            r_x2         <= '0;
            r_y1         <= '0;
            r_y2         <= '0;
            r_strobe     <= 1'b0;
        end else if (advance) begin
            r_prev_pulse <= r_in_pulse;
            r_high_count <= n_high_count;
            r_tick_count <= n_tick_count;
            r_setpoint   <= n_setpoint;
            if (update) begin
                r_x1     <= n_setpoint;
                r_x2     <= r_x1;
                r_y1     <= n_y;
                r_y2     <= r_y1;
                r_strobe <= !r_strobe;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && update) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && update) begin
            r_out_pwm      <= n_y[Y_W-1:FRAC_BITS];
            r_out_setpoint <= n_setpoint;
            r_out_strobe   <= r_strobe;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.pwm_level     = r_out_pwm;
    assign o_out.setpoint      = r_out_setpoint;
    assign o_out.update_strobe = r_out_strobe;

endmodule
